// ===== design/i2c_ras_pkg.sv =====
// Shared types and constants for the I2C register access sequencer.
// Holds stream field layouts, command codes and bus status values.
// No dependencies.
package i2c_ras_pkg;

    // Field widths
    localparam int DEV_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int CMD_W    = 3;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    // Input kinds carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_DONE  = 2'd2
    } opcode_t;

    // Commands to the byte-level bus engine
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_RACK  = 3'd3,
        CMD_RNACK = 3'd4,
        CMD_STOP  = 3'd5
    } bus_cmd_t;

    // Expected masked status codes
    localparam logic [BYTE_W-1:0] ST_MASK   = 8'hF8;
    localparam logic [BYTE_W-1:0] ST_SLA_W  = 8'h18;
    localparam logic [BYTE_W-1:0] ST_DATA_W = 8'h28;
    localparam logic [BYTE_W-1:0] ST_SLA_R  = 8'h40;

    // Input payload, last declared field in the lowest bits
    typedef struct packed {
        logic              pad;
        logic [BYTE_W-1:0] bus_data;
        logic [BYTE_W-1:0] bus_status;
        logic [BYTE_W-1:0] read_len;
        logic [BYTE_W-1:0] write_value;
        logic [BYTE_W-1:0] reg_addr;
        logic [DEV_W-1:0]  dev_addr;
    } in_item_t;

    // Result payload without the command, last declared field in the lowest bits
    typedef struct packed {
        logic [4:0]        pad;
        logic              cmd_rejected;
        logic [BYTE_W-1:0] error_status;
        logic              done_res;
        logic              read_valid;
        logic [BYTE_W-1:0] read_byte;
        logic [BYTE_W-1:0] bus_byte;
    } out_item_t;

endpackage

// ===== design/i2c_register_access_sequencer.sv =====
// Top level of the I2C register access sequencer: transaction state machine
// with a registered result stage. Depends on i2c_ras_pkg.
//
// channel | dir | tdata                                        | tuser
// s_*     | in  | dev_addr, reg_addr, write_value, read_len,   | opcode
//         |     | bus_status, bus_data (48 bits)               |
// m_*     | out | bus_byte, read_byte, read_valid, done_res,   | bus_cmd
//         |     | error_status, cmd_rejected (32 bits)         |
//
// Each input transaction yields one result, registered and valid in the cycle after it is taken.
// One transaction per cycle is sustained while m_tready stays high; the single output register sets that figure.
// s_tready stays high while the output register is empty or being drained.
// A stall on m_tready holds the result and blocks input until it drains.
// Reset returns the sequencer to idle with no result pending.
module i2c_register_access_sequencer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [6:0] dev_addr, [14:7] reg_addr, [22:15] write_value, [30:23] read_len,
    // [38:31] bus_status, [46:39] bus_data, [47] zero
    input  logic [i2c_ras_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] opcode
    input  logic [i2c_ras_pkg::OP_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] bus_byte, [15:8] read_byte, [16] read_valid, [17] done_res,
    // [25:18] error_status, [26] cmd_rejected, [31:27] zero
    output logic [i2c_ras_pkg::M_DATA_W-1:0]    m_tdata,
    // [2:0] bus_cmd
    output logic [i2c_ras_pkg::CMD_W-1:0]       m_tuser
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR_W = 3'd1,
        PH_REG    = 3'd2,
        PH_VAL    = 3'd3,
        PH_ADDR_R = 3'd4,
        PH_READ   = 3'd5
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic                                is_read_reg, is_read_next;
    logic [i2c_ras_pkg::DEV_W-1:0]       saved_dev_reg, saved_dev_next;
    logic [i2c_ras_pkg::BYTE_W-1:0]      saved_reg_reg, saved_reg_next;
    logic [i2c_ras_pkg::BYTE_W-1:0]      saved_value_reg, saved_value_next;
    logic [i2c_ras_pkg::BYTE_W-1:0]      bytes_left_reg, bytes_left_next;
    logic                                out_valid_reg;
    i2c_ras_pkg::out_item_t              out_reg, out_next;
    i2c_ras_pkg::bus_cmd_t               cmd_reg, cmd_next;

    i2c_ras_pkg::in_item_t               in_item;
    i2c_ras_pkg::opcode_t                op;
    logic [i2c_ras_pkg::BYTE_W-1:0]      st;
    logic [i2c_ras_pkg::BYTE_W-1:0]      left_dec;
    logic                                s_acc;
    logic                                m_acc;

    // Handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = cmd_reg;

    // Field decode
    assign in_item  = s_tdata;
    assign op       = i2c_ras_pkg::opcode_t'(s_tuser);
    assign st       = in_item.bus_status & i2c_ras_pkg::ST_MASK;
    assign left_dec = (bytes_left_reg != '0) ? bytes_left_reg - 8'd1 : bytes_left_reg;

    // Next state and result for one input transaction
    always_comb
    begin
        phase_next       = phase_reg;
        is_read_next     = is_read_reg;
        saved_dev_next   = saved_dev_reg;
        saved_reg_next   = saved_reg_reg;
        saved_value_next = saved_value_reg;
        bytes_left_next  = bytes_left_reg;
        out_next         = '0;
        cmd_next         = i2c_ras_pkg::CMD_NONE;

        unique case (op) inside
            i2c_ras_pkg::OP_WRITE, i2c_ras_pkg::OP_READ:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    out_next.cmd_rejected = 1'b1;
                end
                else
                begin
                    is_read_next     = (op == i2c_ras_pkg::OP_READ);
                    saved_dev_next   = in_item.dev_addr;
                    saved_reg_next   = in_item.reg_addr;
                    saved_value_next = in_item.write_value;
                    bytes_left_next  = (in_item.read_len == '0) ? 8'd1 : in_item.read_len;
                    cmd_next         = i2c_ras_pkg::CMD_START;
                    out_next.bus_byte = {in_item.dev_addr, 1'b0};
                    phase_next       = PH_ADDR_W;
                end
            end
            i2c_ras_pkg::OP_DONE:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_ADDR_W:
                    begin
                        if (st != i2c_ras_pkg::ST_SLA_W)
                        begin
                            cmd_next              = i2c_ras_pkg::CMD_STOP;
                            out_next.done_res     = 1'b1;
                            out_next.error_status = st;
                            phase_next            = PH_IDLE;
                        end
                        else
                        begin
                            cmd_next          = i2c_ras_pkg::CMD_WRITE;
                            out_next.bus_byte = saved_reg_reg;
                            phase_next        = PH_REG;
                        end
                    end
                    PH_REG:
                    begin
                        if (st != i2c_ras_pkg::ST_DATA_W)
                        begin
                            cmd_next              = i2c_ras_pkg::CMD_STOP;
                            out_next.done_res     = 1'b1;
                            out_next.error_status = st;
                            phase_next            = PH_IDLE;
                        end
                        else if (is_read_reg)
                        begin
                            cmd_next          = i2c_ras_pkg::CMD_START;
                            out_next.bus_byte = {saved_dev_reg, 1'b1};
                            phase_next        = PH_ADDR_R;
                        end
                        else
                        begin
                            cmd_next          = i2c_ras_pkg::CMD_WRITE;
                            out_next.bus_byte = saved_value_reg;
                            phase_next        = PH_VAL;
                        end
                    end
                    PH_VAL:
                    begin
                        cmd_next          = i2c_ras_pkg::CMD_STOP;
                        out_next.done_res = 1'b1;
                        phase_next        = PH_IDLE;
                        if (st != i2c_ras_pkg::ST_DATA_W)
                        begin
                            out_next.error_status = st;
                        end
                    end
                    PH_ADDR_R:
                    begin
                        if (st != i2c_ras_pkg::ST_SLA_R)
                        begin
                            cmd_next              = i2c_ras_pkg::CMD_STOP;
                            out_next.done_res     = 1'b1;
                            out_next.error_status = st;
                            phase_next            = PH_IDLE;
                        end
                        else
                        begin
                            cmd_next   = (bytes_left_reg > 8'd1) ? i2c_ras_pkg::CMD_RACK
                                                                 : i2c_ras_pkg::CMD_RNACK;
                            phase_next = PH_READ;
                        end
                    end
                    PH_READ:
                    begin
                        // Status is not checked on received bytes
                        out_next.read_byte  = in_item.bus_data;
                        out_next.read_valid = 1'b1;
                        bytes_left_next     = left_dec;
                        if (left_dec == '0)
                        begin
                            cmd_next          = i2c_ras_pkg::CMD_STOP;
                            out_next.done_res = 1'b1;
                            phase_next        = PH_IDLE;
                        end
                        else
                        begin
                            cmd_next = (left_dec > 8'd1) ? i2c_ras_pkg::CMD_RACK
                                                         : i2c_ras_pkg::CMD_RNACK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            is_read_reg     <= 1'b0;
            saved_dev_reg   <= '0;
            saved_reg_reg   <= '0;
            saved_value_reg <= '0;
            bytes_left_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            cmd_reg         <= i2c_ras_pkg::CMD_NONE;
        end
        else
        begin
            if (s_acc)
            begin
                phase_reg       <= phase_next;
                is_read_reg     <= is_read_next;
                saved_dev_reg   <= saved_dev_next;
                saved_reg_reg   <= saved_reg_next;
                saved_value_reg <= saved_value_next;
                bytes_left_reg  <= bytes_left_next;
                out_reg         <= out_next;
                cmd_reg         <= cmd_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Checks
    a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> (cmd_reg == i2c_ras_pkg::CMD_STOP))
        else $error("done result without STOP");

    a_reject_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.cmd_rejected) |-> (cmd_reg == i2c_ras_pkg::CMD_NONE))
        else $error("rejected start issued a bus command");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && out_next.done_res) |=> (phase_reg == PH_IDLE))
        else $error("transaction finished but sequencer not idle");

    a_read_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_READ || phase_reg == PH_ADDR_R) |-> (bytes_left_reg != '0))
        else $error("read phase with no bytes left");

    a_read_byte_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.read_valid) |->
        (cmd_reg == i2c_ras_pkg::CMD_RACK || cmd_reg == i2c_ras_pkg::CMD_RNACK ||
         cmd_reg == i2c_ras_pkg::CMD_STOP))
        else $error("received byte paired with unexpected command");

endmodule

// ===== sim/i2c_register_access_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the I2C register access sequencer: directed and random register accesses,
// bus completions and noise, with every bus command predicted and checked in order.
// Depends on i2c_ras_pkg and i2c_register_access_sequencer.
module i2c_register_access_sequencer_tb;

    // Opcode with no meaning, ignored by the block
    localparam logic [i2c_ras_pkg::OP_W-1:0] OP_NOP = 2'd3;
    localparam int ITEM_TARGET  = 1150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR_W,
        PH_REG,
        PH_VAL,
        PH_ADDR_R,
        PH_READ
    } access_phase_t;

    typedef struct packed {
        i2c_ras_pkg::bus_cmd_t  cmd;
        i2c_ras_pkg::out_item_t fields;
    } bus_result_t;

    // Predicts the next bus command for every input transaction and checks results
    class sequencer_scoreboard;
        access_phase_t                  ph;
        bit                             reading;
        logic [i2c_ras_pkg::DEV_W-1:0]  dev;
        logic [i2c_ras_pkg::BYTE_W-1:0] reg_sel;
        logic [i2c_ras_pkg::BYTE_W-1:0] value;
        logic [i2c_ras_pkg::BYTE_W-1:0] remaining;
        bus_result_t                    expected_q[$];
        int                             mismatches;

        function new();
            ph = PH_IDLE;
            reading = 1'b0;
            dev = '0;
            reg_sel = '0;
            value = '0;
            remaining = '0;
            mismatches = 0;
        endfunction

        function bit busy();
            return ph != PH_IDLE;
        endfunction

        // Status that lets the current phase go on
        function logic [i2c_ras_pkg::BYTE_W-1:0] good_status();
            case (ph)
                PH_ADDR_W:      return i2c_ras_pkg::ST_SLA_W;
                PH_REG, PH_VAL: return i2c_ras_pkg::ST_DATA_W;
                PH_ADDR_R:      return i2c_ras_pkg::ST_SLA_R;
                default:        return 8'h00;
            endcase
        endfunction

        // STOP plus done, back to idle
        function bus_result_t finish_access(logic [i2c_ras_pkg::BYTE_W-1:0] st);
            bus_result_t r;
            r = '0;
            r.cmd = i2c_ras_pkg::CMD_STOP;
            r.fields.done_res = 1'b1;
            r.fields.error_status = st;
            ph = PH_IDLE;
            return r;
        endfunction

        function void note_request(logic [i2c_ras_pkg::OP_W-1:0] op,
                                   i2c_ras_pkg::in_item_t it);
            bus_result_t r;
            logic [i2c_ras_pkg::BYTE_W-1:0] st;
            r = '0;
            st = it.bus_status & i2c_ras_pkg::ST_MASK;
            if (op == i2c_ras_pkg::OP_WRITE || op == i2c_ras_pkg::OP_READ) begin
                // start command: rejected while busy
                if (ph != PH_IDLE) begin
                    r.fields.cmd_rejected = 1'b1;
                end
                else begin
                    reading = (op == i2c_ras_pkg::OP_READ);
                    dev = it.dev_addr;
                    reg_sel = it.reg_addr;
                    value = it.write_value;
                    remaining = (it.read_len == 8'd0) ? 8'd1 : it.read_len;
                    r.cmd = i2c_ras_pkg::CMD_START;
                    r.fields.bus_byte = {dev, 1'b0};
                    ph = PH_ADDR_W;
                end
            end
            else if (op == i2c_ras_pkg::OP_DONE) begin
                case (ph)
                    PH_ADDR_W: begin
                        if (st != i2c_ras_pkg::ST_SLA_W) begin
                            r = finish_access(st);
                        end
                        else begin
                            r.cmd = i2c_ras_pkg::CMD_WRITE;
                            r.fields.bus_byte = reg_sel;
                            ph = PH_REG;
                        end
                    end
                    PH_REG: begin
                        if (st != i2c_ras_pkg::ST_DATA_W) begin
                            r = finish_access(st);
                        end
                        else if (reading) begin
                            r.cmd = i2c_ras_pkg::CMD_START;
                            r.fields.bus_byte = {dev, 1'b1};
                            ph = PH_ADDR_R;
                        end
                        else begin
                            r.cmd = i2c_ras_pkg::CMD_WRITE;
                            r.fields.bus_byte = value;
                            ph = PH_VAL;
                        end
                    end
                    PH_VAL: begin
                        r = finish_access((st != i2c_ras_pkg::ST_DATA_W) ? st : 8'h00);
                    end
                    PH_ADDR_R: begin
                        if (st != i2c_ras_pkg::ST_SLA_R) begin
                            r = finish_access(st);
                        end
                        else begin
                            r.cmd = (remaining > 8'd1) ? i2c_ras_pkg::CMD_RACK
                                                       : i2c_ras_pkg::CMD_RNACK;
                            ph = PH_READ;
                        end
                    end
                    PH_READ: begin
                        // status is not checked on read bytes
                        if (remaining > 8'd0)
                            remaining = remaining - 8'd1;
                        if (remaining == 8'd0)
                            r = finish_access(8'h00);
                        else
                            r.cmd = (remaining > 8'd1) ? i2c_ras_pkg::CMD_RACK
                                                       : i2c_ras_pkg::CMD_RNACK;
                        r.fields.read_byte = it.bus_data;
                        r.fields.read_valid = 1'b1;
                    end
                    default: begin
                        ph = PH_IDLE;
                    end
                endcase
            end
            expected_q.push_back(r);
        endfunction

        function void check_response(logic [i2c_ras_pkg::CMD_W-1:0] cmd,
                                     i2c_ras_pkg::out_item_t got);
            bus_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result with nothing pending: cmd %0d data %h", cmd, got);
                return;
            end
            want = expected_q.pop_front();
            if (cmd !== want.cmd
                || got.bus_byte !== want.fields.bus_byte
                || got.read_byte !== want.fields.read_byte
                || got.read_valid !== want.fields.read_valid
                || got.done_res !== want.fields.done_res
                || got.error_status !== want.fields.error_status
                || got.cmd_rejected !== want.fields.cmd_rejected) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $write("mismatch (expected/actual): cmd %0d/%0d bus_byte %h/%h ",
                           want.cmd, cmd, want.fields.bus_byte, got.bus_byte);
                    $write("read_byte %h/%h read_valid %b/%b done %b/%b ",
                           want.fields.read_byte, got.read_byte,
                           want.fields.read_valid, got.read_valid,
                           want.fields.done_res, got.done_res);
                    $display("error %h/%h rejected %b/%b",
                             want.fields.error_status, got.error_status,
                             want.fields.cmd_rejected, got.cmd_rejected);
                end
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [i2c_ras_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [i2c_ras_pkg::OP_W-1:0]     s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [i2c_ras_pkg::M_DATA_W-1:0] m_tdata;
    logic [i2c_ras_pkg::CMD_W-1:0]    m_tuser;

    sequencer_scoreboard sb;
    int items_sent = 0;
    int src_idle_pct = 10;
    int dst_idle_pct = 78;
    int quiet_cycles = 0;

    i2c_register_access_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_response(m_tuser, i2c_ras_pkg::out_item_t'(m_tdata));
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    function automatic i2c_ras_pkg::in_item_t random_item();
        i2c_ras_pkg::in_item_t it;
        it.pad = 1'b0;
        it.dev_addr = i2c_ras_pkg::DEV_W'($urandom_range(0, 127));
        it.reg_addr = i2c_ras_pkg::BYTE_W'($urandom_range(0, 255));
        it.write_value = i2c_ras_pkg::BYTE_W'($urandom_range(0, 255));
        it.read_len = i2c_ras_pkg::BYTE_W'($urandom_range(0, 255));
        it.bus_status = i2c_ras_pkg::BYTE_W'($urandom_range(0, 255));
        it.bus_data = i2c_ras_pkg::BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    // One input transaction, with random source gaps; noted on acceptance
    task automatic send_item(input logic [i2c_ras_pkg::OP_W-1:0] op,
                             input i2c_ras_pkg::in_item_t it);
        bit taken;
        if (items_sent < ITEM_TARGET / 3) begin
            src_idle_pct = 10;
            dst_idle_pct = 78;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3) begin
            src_idle_pct = 78;
            dst_idle_pct = 10;
        end
        else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        s_tuser <= op;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        sb.note_request(op, it);
        items_sent++;
    endtask

    task automatic issue_start(input logic [i2c_ras_pkg::OP_W-1:0] op,
                               input logic [i2c_ras_pkg::DEV_W-1:0] dev,
                               input logic [i2c_ras_pkg::BYTE_W-1:0] reg_sel,
                               input logic [i2c_ras_pkg::BYTE_W-1:0] value,
                               input logic [i2c_ras_pkg::BYTE_W-1:0] len);
        i2c_ras_pkg::in_item_t it;
        it = random_item();
        it.dev_addr = dev;
        it.reg_addr = reg_sel;
        it.write_value = value;
        it.read_len = len;
        send_item(op, it);
    endtask

    task automatic report_done(input logic [i2c_ras_pkg::BYTE_W-1:0] status,
                               input logic [i2c_ras_pkg::BYTE_W-1:0] data);
        i2c_ras_pkg::in_item_t it;
        it = random_item();
        it.bus_status = status;
        it.bus_data = data;
        send_item(i2c_ras_pkg::OP_DONE, it);
    endtask

    // Well-formed register access with random content, some bad status and noise
    task automatic random_register_access();
        logic [i2c_ras_pkg::OP_W-1:0]   op;
        logic [i2c_ras_pkg::BYTE_W-1:0] len;
        logic [i2c_ras_pkg::BYTE_W-1:0] status;
        op = $urandom_range(0, 1) ? i2c_ras_pkg::OP_READ : i2c_ras_pkg::OP_WRITE;
        if ($urandom_range(0, 99) < 3)
            len = i2c_ras_pkg::BYTE_W'($urandom_range(0, 255));
        else
            len = i2c_ras_pkg::BYTE_W'($urandom_range(0, 5));
        issue_start(op, i2c_ras_pkg::DEV_W'($urandom_range(0, 127)),
                    i2c_ras_pkg::BYTE_W'($urandom_range(0, 255)),
                    i2c_ras_pkg::BYTE_W'($urandom_range(0, 255)), len);
        while (sb.busy()) begin
            if ($urandom_range(0, 99) < 4) begin
                case ($urandom_range(0, 2))
                    0:       op = i2c_ras_pkg::OP_WRITE;
                    1:       op = i2c_ras_pkg::OP_READ;
                    default: op = OP_NOP;
                endcase
                send_item(op, random_item());
            end
            else begin
                status = sb.good_status() | i2c_ras_pkg::BYTE_W'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < 5)
                    status = i2c_ras_pkg::BYTE_W'($urandom_range(0, 255));
                report_done(status, i2c_ras_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // completion while idle, meaningless opcode
        report_done(i2c_ras_pkg::ST_SLA_W, 8'h00);
        send_item(OP_NOP, random_item());

        // write to the top address and register, status low bits set
        issue_start(i2c_ras_pkg::OP_WRITE, 7'h7F, 8'hFF, 8'hA5, 8'h00);
        report_done(8'h1F, 8'h00);
        report_done(i2c_ras_pkg::ST_DATA_W, 8'hFF);
        report_done(8'h2F, 8'h00);

        // start while busy, noise mid-access, zero masked status as failure
        issue_start(i2c_ras_pkg::OP_WRITE, 7'h00, 8'h00, 8'h00, 8'hFF);
        issue_start(i2c_ras_pkg::OP_READ, 7'h55, 8'h12, 8'h34, 8'h02);
        send_item(OP_NOP, random_item());
        report_done(8'h05, 8'h00);

        // read with length zero
        issue_start(i2c_ras_pkg::OP_READ, 7'h00, 8'h10, 8'h00, 8'h00);
        report_done(i2c_ras_pkg::ST_SLA_W, 8'h00);
        report_done(i2c_ras_pkg::ST_DATA_W, 8'h00);
        report_done(i2c_ras_pkg::ST_SLA_R, 8'h00);
        report_done(8'hFF, 8'hFF);

        // two-byte read, ACK then NACK
        issue_start(i2c_ras_pkg::OP_READ, 7'h2A, 8'h80, 8'hFF, 8'h02);
        report_done(8'h18, 8'h00);
        report_done(8'h28, 8'h00);
        report_done(8'h47, 8'h00);
        report_done(8'h00, 8'h5A);
        report_done(8'h07, 8'hA5);

        // write fails on the register byte
        issue_start(i2c_ras_pkg::OP_WRITE, 7'h01, 8'h01, 8'h01, 8'h01);
        report_done(i2c_ras_pkg::ST_SLA_W, 8'h00);
        report_done(8'h20, 8'h00);

        // read fails on the read address
        issue_start(i2c_ras_pkg::OP_READ, 7'h40, 8'h7F, 8'h00, 8'h80);
        report_done(i2c_ras_pkg::ST_SLA_W, 8'h00);
        report_done(i2c_ras_pkg::ST_DATA_W, 8'h00);
        report_done(8'h48, 8'h00);

        // random part
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 85)
                random_register_access();
            else
                send_item(i2c_ras_pkg::OP_W'($urandom_range(0, 3)), random_item());
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
